// File: rtl/raru_pkg.sv
package raru_pkg;

	// Command codes carried on the command field.
	localparam logic [1:0] CMD_REDUCE = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_ADDINT = 2'd2;
	localparam logic [1:0] CMD_MUL    = 2'd3;

	typedef enum logic {
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_rsp_t;

	// Where the shared gcd routine returns to when it finishes.
	typedef enum logic {
		RET_ADD,
		RET_FINAL
	} gcd_ret_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM,
		ST_GCD_SWAP,
		ST_GCD_LOOP,
		ST_ADD_MUL,
		ST_ADD_U,
		ST_ADD_Q1,
		ST_ADD_M1,
		ST_ADD_Q2,
		ST_ADD_M2,
		ST_INT_MUL,
		ST_MUL_N,
		ST_MUL_D,
		ST_FIN_N,
		ST_FIN_D,
		ST_DONE
	} state_t;

endpackage

// File: rtl/raru_alu.sv
module raru_alu #(
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  raru_pkg::alu_req_t       req,
	input  logic signed [WIDTH-1:0]  opx,
	input  logic signed [WIDTH-1:0]  opy,
	output raru_pkg::alu_rsp_t       rsp,
	output logic signed [WIDTH-1:0]  quo,
	output logic signed [WIDTH-1:0]  rem
);
	import raru_pkg::*;

	localparam int CW = $clog2(WIDTH);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	alu_op_t       op_q;

	logic [WIDTH-1:0]        r_q;
	logic [WIDTH-1:0]        q_q;
	logic [WIDTH-1:0]        d_q;
	logic                    xneg_q;
	logic                    qneg_q;
	logic                    dz_q;
	logic signed [WIDTH-1:0] x_q;

	logic [WIDTH-1:0] mag_x;
	logic [WIDTH-1:0] mag_y;
	logic [WIDTH:0]   rs;
	logic [WIDTH:0]   diff;
	logic [WIDTH-1:0] r_nx;
	logic [WIDTH-1:0] q_nx;
	logic [WIDTH-1:0] d_nx;

	assign mag_x = opx[WIDTH-1] ? $unsigned(-opx) : $unsigned(opx);
	assign mag_y = opy[WIDTH-1] ? $unsigned(-opy) : $unsigned(opy);

	// One restoring division bit or one shift-and-add multiply bit per cycle.
	always_comb begin
		rs   = {r_q, q_q[WIDTH-1]};
		diff = rs - {1'b0, d_q};
		if (op_q == ALU_DIV) begin
			r_nx = diff[WIDTH] ? rs[WIDTH-1:0] : diff[WIDTH-1:0];
			q_nx = {q_q[WIDTH-2:0], ~diff[WIDTH]};
			d_nx = d_q;
		end else begin
			r_nx = r_q + (q_q[0] ? d_q : '0);
			q_nx = q_q >> 1;
			d_nx = d_q << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= ALU_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH - 1);
				op_q   <= req.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q    <= '0;
			xneg_q <= opx[WIDTH-1];
			qneg_q <= opx[WIDTH-1] ^ opy[WIDTH-1];
			dz_q   <= (opy == '0);
			x_q    <= opx;
			if (req.op == ALU_DIV) begin
				q_q <= mag_x;
				d_q <= mag_y;
			end else begin
				q_q <= $unsigned(opy);
				d_q <= $unsigned(opx);
			end
		end else if (busy_q) begin
			r_q <= r_nx;
			q_q <= q_nx;
			d_q <= d_nx;
		end
	end

	// Truncating signed results; a zero divisor gives quotient 0 and the dividend back.
	always_comb begin
		if (op_q == ALU_MUL) begin
			quo = $signed(r_q);
		end else if (dz_q) begin
			quo = '0;
		end else if (qneg_q) begin
			quo = $signed(-q_q);
		end else begin
			quo = $signed(q_q);
		end
		if (dz_q) begin
			rem = x_q;
		end else if (xneg_q) begin
			rem = $signed(-r_q);
		end else begin
			rem = $signed(r_q);
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;

endmodule

// File: rtl/rational_arith_reduce_unit_top.sv
// Fraction arithmetic unit. Each input word carries a command and two fractions
// A = a_num/a_den and B = b_num/b_den; the unit reduces A, adds A+B, adds the integer
// b_num to A, or multiplies A*B, then reduces the result by a Euclidean gcd (swap when
// the first operand is smaller, signed remainder loop, divide both parts by the gcd).
// All arithmetic wraps at WIDTH bits; operands are sign-extended or truncated to WIDTH
// and results are sign-extended back to 32 bits. The result denominator keeps the sign
// that the gcd rule leaves, so it may be negative. A zero unreduced denominator sets
// zero_den_error and is replaced by 1 before reduction. All multiplications and
// divisions go through one shared bit-serial unit, and the sequencer tests for a zero
// remainder before each gcd remainder step. The sequencer also takes steps for
// decoding, the zero-denominator check, the gcd swap, the loop exit and the hand-off to
// the output register. A reduce, an add of equal denominators, an integer add or a
// multiply runs one gcd and at most four operations. An add of unequal denominators
// also runs a first gcd on the two denominators and six more operations. A new word
// is taken only while the sequencer is idle, but a finished result sits in an output
// register, so the next word can be accepted while the previous result still waits
// to be taken.
module rational_arith_reduce_unit_top #(
	parameter int WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic signed [31:0] a_num,
	input  logic signed [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic signed [31:0] b_den,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] res_num,
	output logic signed [31:0] res_den,
	output logic               zero_den_error
);
	import raru_pkg::*;

	state_t   state_q, state_d;
	logic     pending_q, pending_d;
	gcd_ret_t gret_q, gret_d;
	logic     err_q, err_d;

	// Operands as taken from the input word.
	logic signed [WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
	logic signed [WIDTH-1:0] an_w, ad_w, bn_w, bd_w;

	// Working registers of the sequencer.
	logic signed [WIDTH-1:0] num_q, num_d;
	logic signed [WIDTH-1:0] den_q, den_d;
	logic signed [WIDTH-1:0] t_q, t_d;
	logic signed [WIDTH-1:0] u_q, u_d;
	logic signed [WIDTH-1:0] w_q, w_d;
	logic signed [WIDTH-1:0] ga_q, ga_d;
	logic signed [WIDTH-1:0] gb_q, gb_d;

	// Output register.
	logic               out_valid_q;
	logic signed [31:0] res_num_q;
	logic signed [31:0] res_den_q;
	logic               res_err_q;
	logic               load_out;

	alu_req_t                alu_req;
	alu_rsp_t                alu_rsp;
	logic signed [WIDTH-1:0] alu_x, alu_y;
	logic signed [WIDTH-1:0] alu_quo, alu_rem;

	assign an_w = WIDTH'(a_num);
	assign ad_w = WIDTH'(a_den);
	assign bn_w = WIDTH'(b_num);
	assign bd_w = WIDTH'(b_den);

	assign in_ready = (state_q == ST_IDLE);

	raru_alu #(
		.WIDTH(WIDTH)
	) u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.opx   (alu_x),
		.opy   (alu_y),
		.rsp   (alu_rsp),
		.quo   (alu_quo),
		.rem   (alu_rem)
	);

	// Each operation state starts the shared unit once (the gcd loop state once per remainder
	// step), then waits for its done pulse and stores the result.
	always_comb begin
		state_d       = state_q;
		pending_d     = pending_q;
		gret_d        = gret_q;
		err_d         = err_q;
		num_d         = num_q;
		den_d         = den_q;
		t_d           = t_q;
		u_d           = u_q;
		w_d           = w_q;
		ga_d          = ga_q;
		gb_d          = gb_q;
		alu_req.start = 1'b0;
		alu_req.op    = ALU_DIV;
		alu_x         = num_q;
		alu_y         = den_q;
		load_out      = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (command)
						CMD_REDUCE: begin
							num_d   = an_w;
							den_d   = ad_w;
							state_d = ST_NORM;
						end
						CMD_ADD: begin
							if (ad_w == bd_w) begin
								num_d   = an_w + bn_w;
								den_d   = ad_w;
								state_d = ST_NORM;
							end else begin
								ga_d    = ad_w;
								gb_d    = bd_w;
								gret_d  = RET_ADD;
								state_d = ST_GCD_SWAP;
							end
						end
						CMD_ADDINT: state_d = ST_INT_MUL;
						CMD_MUL:    state_d = ST_MUL_N;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_NORM: begin
				ga_d   = num_q;
				gret_d = RET_FINAL;
				if (den_q == '0) begin
					err_d = 1'b1;
					den_d = WIDTH'(1);
					gb_d  = WIDTH'(1);
				end else begin
					err_d = 1'b0;
					gb_d  = den_q;
				end
				state_d = ST_GCD_SWAP;
			end
			ST_GCD_SWAP: begin
				if (ga_q < gb_q) begin
					ga_d = gb_q;
					gb_d = ga_q;
				end
				state_d = ST_GCD_LOOP;
			end
			ST_GCD_LOOP: begin
				alu_x = ga_q;
				alu_y = gb_q;
				if (pending_q) begin
					if (alu_rsp.done) begin
						pending_d = 1'b0;
						ga_d      = gb_q;
						gb_d      = alu_rem;
					end
				end else if (gb_q == '0) begin
					// A zero gcd is replaced by 1 so that the following divides are defined.
					w_d     = (ga_q == '0) ? WIDTH'(1) : ga_q;
					state_d = (gret_q == RET_ADD) ? ST_ADD_MUL : ST_FIN_N;
				end else begin
					alu_req.start = 1'b1;
					pending_d     = 1'b1;
				end
			end
			ST_ADD_MUL: begin
				alu_req.start = !pending_q;
				alu_req.op    = ALU_MUL;
				alu_x         = ad_q;
				alu_y         = bd_q;
				pending_d     = 1'b1;
				if (pending_q && alu_rsp.done) begin
					pending_d = 1'b0;
					t_d       = alu_quo;
					state_d   = ST_ADD_U;
				end
			end
			ST_ADD_U: begin
				alu_req.start = !pending_q;
				alu_x         = t_q;
				alu_y         = w_q;
				pending_d     = 1'b1;
				if (pending_q && alu_rsp.done) begin
					pending_d = 1'b0;
					u_d       = alu_quo;
					state_d   = ST_ADD_Q1;
				end
			end
			ST_ADD_Q1: begin
				alu_req.start = !pending_q;
				alu_x         = u_q;
				alu_y         = ad_q;
				pending_d     = 1'b1;
				if (pending_q && alu_rsp.done) begin
					pending_d = 1'b0;
					t_d       = alu_quo;
					state_d   = ST_ADD_M1;
				end
			end
			ST_ADD_M1: begin
				alu_req.start = !pending_q;
				alu_req.op    = ALU_MUL;
				alu_x         = t_q;
				alu_y         = an_q;
				pending_d     = 1'b1;
				if (pending_q && alu_rsp.done) begin
					pending_d = 1'b0;
					num_d     = alu_quo;
					state_d   = ST_ADD_Q2;
				end
			end
			ST_ADD_Q2: begin
				alu_req.start = !pending_q;
				alu_x         = u_q;
				alu_y         = bd_q;
				pending_d     = 1'b1;
				if (pending_q && alu_rsp.done) begin
					pending_d = 1'b0;
					t_d       = alu_quo;
					state_d   = ST_ADD_M2;
				end
			end
			ST_ADD_M2: begin
				alu_req.start = !pending_q;
				alu_req.op    = ALU_MUL;
				alu_x         = t_q;
				alu_y         = bn_q;
				pending_d     = 1'b1;
				if (pending_q && alu_rsp.done) begin
					pending_d = 1'b0;
					num_d     = num_q + alu_quo;
					den_d     = u_q;
					state_d   = ST_NORM;
				end
			end
			ST_INT_MUL: begin
				alu_req.start = !pending_q;
				alu_req.op    = ALU_MUL;
				alu_x         = bn_q;
				alu_y         = ad_q;
				pending_d     = 1'b1;
				if (pending_q && alu_rsp.done) begin
					pending_d = 1'b0;
					num_d     = alu_quo + an_q;
					den_d     = ad_q;
					state_d   = ST_NORM;
				end
			end
			ST_MUL_N: begin
				alu_req.start = !pending_q;
				alu_req.op    = ALU_MUL;
				alu_x         = an_q;
				alu_y         = bn_q;
				pending_d     = 1'b1;
				if (pending_q && alu_rsp.done) begin
					pending_d = 1'b0;
					num_d     = alu_quo;
					state_d   = ST_MUL_D;
				end
			end
			ST_MUL_D: begin
				alu_req.start = !pending_q;
				alu_req.op    = ALU_MUL;
				alu_x         = ad_q;
				alu_y         = bd_q;
				pending_d     = 1'b1;
				if (pending_q && alu_rsp.done) begin
					pending_d = 1'b0;
					den_d     = alu_quo;
					state_d   = ST_NORM;
				end
			end
			ST_FIN_N: begin
				alu_req.start = !pending_q;
				alu_x         = num_q;
				alu_y         = w_q;
				pending_d     = 1'b1;
				if (pending_q && alu_rsp.done) begin
					pending_d = 1'b0;
					num_d     = alu_quo;
					state_d   = ST_FIN_D;
				end
			end
			ST_FIN_D: begin
				alu_req.start = !pending_q;
				alu_x         = den_q;
				alu_y         = w_q;
				pending_d     = 1'b1;
				if (pending_q && alu_rsp.done) begin
					pending_d = 1'b0;
					den_d     = alu_quo;
					state_d   = ST_DONE;
				end
			end
			ST_DONE: begin
				// Hand the result to the output register as soon as it is free.
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			pending_q <= pending_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			an_q <= an_w;
			ad_q <= ad_w;
			bn_q <= bn_w;
			bd_q <= bd_w;
		end
		gret_q <= gret_d;
		err_q  <= err_d;
		num_q  <= num_d;
		den_q  <= den_d;
		t_q    <= t_d;
		u_q    <= u_d;
		w_q    <= w_d;
		ga_q   <= ga_d;
		gb_q   <= gb_d;
		if (load_out) begin
			res_num_q <= 32'(num_q);
			res_den_q <= 32'(den_q);
			res_err_q <= err_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign res_num        = res_num_q;
	assign res_den        = res_den_q;
	assign zero_den_error = res_err_q;

`ifndef SYNTHESIS
	// The shared unit is never restarted while an operation is still running.
	assert property (@(posedge clk) disable iff (!arst_n)
		alu_req.start |-> !alu_rsp.busy)
	else $error("shared unit started while busy");

	// A done pulse only ever answers an operation the sequencer is waiting for.
	assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> pending_q)
	else $error("unexpected done from shared unit");

	// While a new word can be taken, no operation may be left running.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!alu_rsp.busy && !pending_q))
	else $error("input ready while shared unit is active");

	// A forced denominator of one reduces only to plus or minus one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && zero_den_error) |-> (res_den == 32'sd1 || res_den == -32'sd1))
	else $error("bad denominator after zero-denominator fix");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import raru_pkg::*;

	// Handshake and run limits.
	localparam int QUIET_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 2000;
	localparam int RANDOM_WORDS = 350;
	localparam int HOLD_AT      = 60;
	localparam int HOLD_CYCLES  = 3000;
	localparam int BURST_FIRST  = 150;
	localparam int BURST_LAST   = 210;

	localparam logic [31:0] S_MIN = 32'h8000_0000;
	localparam logic [31:0] S_MAX = 32'h7fff_ffff;

	// One reduced fraction as the unit should present it.
	typedef struct packed {
		logic [31:0] num;
		logic [31:0] den;
		logic        zero_den;
	} fraction_t;

	// Scoreboard. It holds its own fraction arithmetic: every operation is done on
	// 32-bit vectors that wrap, with truncating signed division and a remainder
	// that takes the sign of the dividend, exactly as the unit does at WIDTH = 32.
	class fraction_scoreboard;
		fraction_t pending_fractions[$];
		int        errors;
		int        checked;
		int        zero_den_seen;
		int        per_command[4];

		function new();
			errors = 0;
			checked = 0;
			zero_den_seen = 0;
			foreach (per_command[i])
				per_command[i] = 0;
		endfunction

		function logic [31:0] magnitude(logic [31:0] v);
			return v[31] ? -v : v;
		endfunction

		// A zero divisor yields a zero quotient; the most negative value over
		// minus one wraps back to itself.
		function logic [31:0] trunc_div(logic [31:0] a, logic [31:0] b);
			logic [31:0] q;
			if (magnitude(b) == 0)
				return 32'd0;
			q = magnitude(a) / magnitude(b);
			return (a[31] != b[31]) ? -q : q;
		endfunction

		function logic [31:0] trunc_rem(logic [31:0] a, logic [31:0] b);
			logic [31:0] r;
			if (magnitude(b) == 0)
				return a;
			r = magnitude(a) % magnitude(b);
			return a[31] ? -r : r;
		endfunction

		// Swap when the first operand is smaller (signed), then the plain
		// remainder loop. The sign of the gcd is whatever the loop leaves.
		function logic [31:0] euclid_gcd(logic [31:0] x, logic [31:0] y);
			logic [31:0] t;
			if ($signed(x) < $signed(y)) begin
				t = x;
				x = y;
				y = t;
			end
			while (y != 0) begin
				t = trunc_rem(x, y);
				x = y;
				y = t;
			end
			return x;
		endfunction

		function fraction_t compute_fraction(logic [1:0] cmd, logic [31:0] an,
				logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
			fraction_t   f;
			logic [31:0] num, den, w, u, p, m;
			f.zero_den = 1'b0;
			case (cmd)
				CMD_REDUCE: begin
					num = an;
					den = ad;
				end
				CMD_ADD: begin
					if (ad == bd) begin
						num = an + bn;
						den = ad;
					end else begin
						w = euclid_gcd(ad, bd);
						if (w == 0)
							w = 32'd1;
						p = ad * bd;
						u = trunc_div(p, w);
						num = trunc_div(u, ad) * an + trunc_div(u, bd) * bn;
						den = u;
					end
				end
				CMD_ADDINT: begin
					num = bn * ad + an;
					den = ad;
				end
				default: begin
					num = an * bn;
					den = ad * bd;
				end
			endcase
			if (den == 0) begin
				f.zero_den = 1'b1;
				den = 32'd1;
			end
			m = euclid_gcd(num, den);
			if (m == 0)
				m = 32'd1;
			f.num = trunc_div(num, m);
			f.den = trunc_div(den, m);
			return f;
		endfunction

		function void note_word(logic [1:0] cmd, logic [31:0] an, logic [31:0] ad,
				logic [31:0] bn, logic [31:0] bd);
			fraction_t f;
			f = compute_fraction(cmd, an, ad, bn, bd);
			per_command[cmd]++;
			if (f.zero_den)
				zero_den_seen++;
			pending_fractions.push_back(f);
		endfunction

		function void check_result(logic [31:0] num, logic [31:0] den, logic zero_den);
			fraction_t f;
			checked++;
			if (pending_fractions.size() == 0) begin
				errors++;
				$display("%0t: result %0d/%0d arrived with nothing expected", $time,
					$signed(num), $signed(den));
				return;
			end
			f = pending_fractions.pop_front();
			if (num !== f.num) begin
				errors++;
				$display("%0t: res_num expected %0d, got %0d", $time, $signed(f.num),
					$signed(num));
			end
			if (den !== f.den) begin
				errors++;
				$display("%0t: res_den expected %0d, got %0d", $time, $signed(f.den),
					$signed(den));
			end
			if (zero_den !== f.zero_den) begin
				errors++;
				$display("%0t: zero_den_error expected %0b, got %0b", $time, f.zero_den,
					zero_den);
			end
		endfunction

		function int outstanding();
			return pending_fractions.size();
		endfunction
	endclass

	// Clock, reset and the block's ports. Every input starts at a known value.
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        command = CMD_REDUCE;
	logic signed [31:0] a_num = '0;
	logic signed [31:0] a_den = '0;
	logic signed [31:0] b_num = '0;
	logic signed [31:0] b_den = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic signed [31:0] res_num;
	logic signed [31:0] res_den;
	logic              zero_den_error;

	fraction_scoreboard sb;
	int                 sent_count = 0;
	int                 quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rational_arith_reduce_unit_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.a_num         (a_num),
		.a_den         (a_den),
		.b_num         (b_num),
		.b_den         (b_den),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.res_num       (res_num),
		.res_den       (res_den),
		.zero_den_error(zero_den_error)
	);

	// Operand mix. Small values dominate: they keep the Euclid loop short, hit
	// equal denominators and zeros often, and give results that really reduce.
	// Full-range and boundary values still appear in a fair share of words.
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 32) - 16;
			4, 5: return $urandom_range(0, 2000) - 1000;
			6, 7: return $urandom();
			8: begin
				case ($urandom_range(0, 5))
					0: return S_MIN;
					1: return S_MAX;
					2: return 32'd0;
					3: return 32'd1;
					4: return 32'hffff_ffff;
					default: return S_MIN + 32'd1;
				endcase
			end
			default: return $urandom() >> $urandom_range(0, 31);
		endcase
	endfunction

	// Offers one word and returns at the edge where it is accepted, leaving
	// in_valid high. A gap lowers valid first; with no gap the next word follows
	// directly, so valid is never dropped and raised in the same step. Inside the
	// burst window the sender does not idle at all.
	task automatic send_word(input logic [1:0] cmd, input logic [31:0] an,
			input logic [31:0] ad, input logic [31:0] bn, input logic [31:0] bd);
		int gap;
		gap = (sent_count >= BURST_FIRST && sent_count < BURST_LAST) ? 0 :
			$urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		a_num    <= an;
		a_den    <= ad;
		b_num    <= bn;
		b_den    <= bd;
		do @(posedge clk); while (!in_ready);
		sb.note_word(cmd, an, ad, bn, bd);
		sent_count++;
	endtask

	// Result side. The receiver stalls a random number of cycles before each
	// result, never stalls inside the burst window, and once holds off for a long
	// stretch so that a result sits in the output register, the next word is
	// taken and computed, and the unit then has to refuse further input.
	initial begin : result_sink
		int stall;
		int taken;
		taken = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = (taken >= BURST_FIRST && taken < BURST_LAST) ? 0 :
				$urandom_range(0, 11);
			if (taken == HOLD_AT)
				stall += HOLD_CYCLES;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// Every result word taken at an edge is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(res_num, res_den, zero_den_error);
	end

	// The watchdog counts edges at which no word moves on either side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("%0t: timeout, no word moved for %0d cycles", $time, QUIET_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		logic [1:0]  cmd;
		logic [31:0] an, ad, bn, bd;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: plain reductions, a negative numerator, zero numerator,
		// zero denominator, and the most negative value over minus one.
		send_word(CMD_REDUCE, 32'd6, 32'd4, 32'd0, 32'd0);
		send_word(CMD_REDUCE, -32'd6, 32'd4, 32'd0, 32'd0);
		send_word(CMD_REDUCE, 32'd0, 32'd5, 32'd0, 32'd0);
		send_word(CMD_REDUCE, 32'd7, 32'd0, 32'd0, 32'd0);
		send_word(CMD_REDUCE, S_MIN, 32'hffff_ffff, 32'd0, 32'd0);
		send_word(CMD_REDUCE, S_MAX, S_MIN, S_MAX, S_MIN);
		send_word(CMD_REDUCE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		// Additions: shared denominator, different denominators, a zero
		// denominator on one side only, zero on both, and boundary denominators.
		send_word(CMD_ADD, 32'd1, 32'd3, 32'd1, 32'd3);
		send_word(CMD_ADD, 32'd1, 32'd4, 32'd1, 32'd6);
		send_word(CMD_ADD, 32'd1, 32'd0, 32'd2, 32'd5);
		send_word(CMD_ADD, 32'd3, 32'd0, 32'd4, 32'd0);
		send_word(CMD_ADD, S_MAX, S_MAX, S_MIN, S_MIN);
		send_word(CMD_ADD, S_MAX, S_MIN, S_MIN, S_MAX);
		// Integer additions, including a zero denominator and wrapping terms.
		send_word(CMD_ADDINT, 32'd1, 32'd3, 32'd5, 32'd0);
		send_word(CMD_ADDINT, 32'd2, 32'd0, 32'd3, 32'd0);
		send_word(CMD_ADDINT, S_MAX, 32'hffff_ffff, S_MIN, 32'd7);
		// Products, including a denominator that wraps to zero.
		send_word(CMD_MUL, 32'd2, 32'd3, 32'd9, 32'd4);
		send_word(CMD_MUL, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		send_word(CMD_MUL, S_MIN, S_MIN, 32'hffff_ffff, 32'hffff_ffff);
		send_word(CMD_MUL, 32'd0, 32'd0, 32'd0, 32'd0);
		send_word(CMD_MUL, S_MAX, S_MAX, S_MAX, S_MAX);

		// Random words. A quarter of the additions share one denominator so that
		// both addition paths get steady traffic.
		repeat (RANDOM_WORDS) begin
			cmd = 2'($urandom_range(0, 3));
			an = pick_operand();
			ad = pick_operand();
			bn = pick_operand();
			bd = (cmd == CMD_ADD && $urandom_range(0, 3) == 0) ? ad : pick_operand();
			send_word(cmd, an, ad, bn, bd);
		end
		in_valid <= 1'b0;

		// Wait for every prediction to be met, then watch a while longer for
		// results that should not be there.
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d words: %0d reduce, %0d add, %0d add-integer, %0d multiply.",
			sent_count, sb.per_command[CMD_REDUCE], sb.per_command[CMD_ADD],
			sb.per_command[CMD_ADDINT], sb.per_command[CMD_MUL]);
		$display("%0d results checked, %0d with a zero denominator, %0d mismatches.",
			sb.checked, sb.zero_den_seen, sb.errors);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
